[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a full property.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/gbrs_pkg.sv]
`timescale 1ns / 1ps

package gbrs_pkg;

	localparam int CLUSTER_W = 17;
	localparam int OFFSET_W  = 48;
	localparam int LENGTH_W  = 32;
	localparam int INDEX_W   = 6;
	// Wide enough for the running base plus one block at the largest cluster
	localparam int SIZE_W    = 52;
	localparam int PROD_W    = 20;

	localparam logic [CLUSTER_W-1:0] CLUSTER_RESET = 17'd4096;
	localparam logic [INDEX_W-1:0]   MAX_SEG       = 6'd63;
	localparam logic [INDEX_W-1:0]   FIRST_GROWN   = 6'd5;
	localparam logic [INDEX_W-1:0]   GROW_BASE     = 6'd4;
	localparam logic [2:0]           MULT_FIRST    = 3'd1;
	localparam logic [2:0]           MULT_EVEN     = 3'd4;
	localparam logic [2:0]           MULT_ODD      = 3'd6;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_BEYOND = 1'b1;

	typedef struct packed {
		logic [OFFSET_W-1:0] start_offset;
		logic [LENGTH_W-1:0] request_length;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  block_index;
		logic [OFFSET_W-1:0] offset_in_block;
		logic [LENGTH_W-1:0] segment_length;
		logic                status;
		logic                last_segment;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic walk;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic len_zero;
		logic walk_done;
		logic seg_last;
		logic out_free;
	} dp_sts_t;

	// Bytes in block idx: a small multiplier times the cluster, then a shift
	function automatic logic [SIZE_W-1:0] block_bytes(input logic [INDEX_W-1:0] idx,
			input logic [CLUSTER_W-1:0] cluster);
		logic [2:0]        mult;
		logic [4:0]        sh;
		logic [INDEX_W-1:0] grown;
		logic [PROD_W-1:0] prod;
		grown = idx - GROW_BASE;
		if (idx == '0) begin
			mult = MULT_FIRST;
			sh   = '0;
		end else if (idx < FIRST_GROWN) begin
			mult = idx[2:0];
			sh   = '0;
		end else if (!idx[0]) begin
			mult = MULT_EVEN;
			sh   = grown[5:1];
		end else begin
			mult = MULT_ODD;
			sh   = grown[5:1];
		end
		prod = PROD_W'(cluster) * PROD_W'(mult);
		return SIZE_W'(prod) << sh;
	endfunction

endpackage

[rtl/growing_block_request_splitter.sv]
`timescale 1ns / 1ps
// Splits a byte request over a chain of NUM_BLOCKS blocks of growing size.
// Input channel (in_valid/in_stall/in_data): start offset and length. An
// item is taken when in_valid is high and in_stall low; in_stall stays
// high from the cycle after a nonzero-length item until its last segment
// has been loaded into the output register. A zero-length item gives no
// output and is done in its accept cycle.
// Output channel (out_valid/out_stall/out_data): one item per block the
// request touches, the final one marked. A start or continuation beyond
// the last block gives one item with status set, which ends the request.
// Timing: for a start in block k the walk steps through blocks 0 to k
// (one adder and compare steps one block per cycle), then one segment per
// cycle enters the output register while the receiver does not stall.
// When the receiver stalls, the output register holds its item and the
// segment sequencer waits. cfg_wr_en/cfg_wr_data write the cluster size;
// the user must write it only while the block is idle, as the block
// itself does not enforce this.
// Reset clears the sequencer and the output valid and sets the cluster
// size to 4096 bytes.
module growing_block_request_splitter #(
	parameter int NUM_BLOCKS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [gbrs_pkg::CLUSTER_W-1:0] cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  gbrs_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output gbrs_pkg::out_item_t            out_data
);

	gbrs_pkg::dp_cmd_t cmd;
	gbrs_pkg::dp_sts_t sts;

	// Sequencer
	gbrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Walk, segment arithmetic and output register
	gbrs_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

[rtl/gbrs_ctrl.sv]
`timescale 1ns / 1ps

module gbrs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output gbrs_pkg::dp_cmd_t cmd,
	input  gbrs_pkg::dp_sts_t sts
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Take a new item only between requests
	assign in_stall = (state_q != ST_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid && !sts.len_zero) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free && sts.seg_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/gbrs_datapath.sv]
`timescale 1ns / 1ps

module gbrs_datapath #(
	parameter int NUM_BLOCKS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gbrs_pkg::CLUSTER_W-1:0]    cfg_wr_data,
	input  gbrs_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output gbrs_pkg::out_item_t               out_data,
	input  gbrs_pkg::dp_cmd_t                 cmd,
	output gbrs_pkg::dp_sts_t                 sts
);

	localparam int BLK_W = $clog2(NUM_BLOCKS + 1);
	localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(NUM_BLOCKS);

	logic [gbrs_pkg::CLUSTER_W-1:0] cluster_q;
	logic [gbrs_pkg::OFFSET_W-1:0]  addr_q;
	logic [gbrs_pkg::LENGTH_W-1:0]  remaining_q;
	logic [gbrs_pkg::SIZE_W-1:0]    base_q;
	logic [gbrs_pkg::OFFSET_W-1:0]  off_q;
	logic [BLK_W-1:0]               blk_q;
	logic [gbrs_pkg::INDEX_W-1:0]   count_q;
	logic                           out_valid_q;
	gbrs_pkg::out_item_t            out_q;

	logic [gbrs_pkg::SIZE_W-1:0]    size;
	logic [gbrs_pkg::SIZE_W-1:0]    base_sum;
	logic [gbrs_pkg::SIZE_W-1:0]    room;
	logic [gbrs_pkg::LENGTH_W-1:0]  take;
	logic [gbrs_pkg::LENGTH_W-1:0]  rem_next;
	logic                           at_end;
	logic                           hit;
	logic                           seg_err;

	// Size of the current block and the walk compare
	assign size     = gbrs_pkg::block_bytes(gbrs_pkg::INDEX_W'(blk_q), cluster_q);
	assign base_sum = base_q + size;
	assign at_end   = (blk_q >= LAST_BLK);
	assign hit      = base_sum > gbrs_pkg::SIZE_W'(addr_q);

	// Segment in the current block
	assign seg_err  = at_end || (count_q == gbrs_pkg::MAX_SEG);
	assign room     = size - gbrs_pkg::SIZE_W'(off_q);
	assign take     = (room < gbrs_pkg::SIZE_W'(remaining_q)) ?
		room[gbrs_pkg::LENGTH_W-1:0] : remaining_q;
	assign rem_next = remaining_q - take;

	assign sts.len_zero  = (in_data.request_length == '0);
	assign sts.walk_done = at_end || hit;
	assign sts.seg_last  = seg_err || (rem_next == '0);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Cluster size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_q <= gbrs_pkg::CLUSTER_RESET;
		end else if (cfg_wr_en) begin
			cluster_q <= cfg_wr_data;
		end
	end

	// Request state: load, walk the blocks, advance per segment
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q      <= in_data.start_offset;
			remaining_q <= in_data.request_length;
			base_q      <= '0;
			off_q       <= '0;
			blk_q       <= '0;
			count_q     <= '0;
		end else if (cmd.walk && !at_end) begin
			if (hit) begin
				off_q <= addr_q - base_q[gbrs_pkg::OFFSET_W-1:0];
			end else begin
				base_q <= base_sum;
				blk_q  <= blk_q + 1'b1;
			end
		end else if (cmd.emit && !seg_err) begin
			remaining_q <= rem_next;
			blk_q       <= blk_q + 1'b1;
			off_q       <= '0;
			count_q     <= count_q + 1'b1;
		end
	end

	// Output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (seg_err) begin
				out_q.block_index     <= '0;
				out_q.offset_in_block <= '0;
				out_q.segment_length  <= remaining_q;
				out_q.status          <= gbrs_pkg::STATUS_BEYOND;
				out_q.last_segment    <= 1'b1;
			end else begin
				out_q.block_index     <= gbrs_pkg::INDEX_W'(blk_q);
				out_q.offset_in_block <= off_q;
				out_q.segment_length  <= take;
				out_q.status          <= gbrs_pkg::STATUS_OK;
				out_q.last_segment    <= (rem_next == '0);
			end
		end
	end

endmodule

[rtl/gbrs_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gbrs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input gbrs_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input gbrs_pkg::out_item_t out_data
);

	// Stalled output item holds
	`ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "output item changed while stalled")

	// Error item always ends the request and carries no position
	`ASSERT_IMPLIES(a_err_last, out_valid && out_data.status == gbrs_pkg::STATUS_BEYOND, out_data.last_segment && out_data.block_index == '0 && out_data.offset_in_block == '0, "error item malformed")

	// Normal segment never empty
	`ASSERT_IMPLIES(a_seg_nonzero, out_valid && out_data.status == gbrs_pkg::STATUS_OK, out_data.segment_length != '0, "empty segment emitted")

	// Nonzero request blocks the input next cycle
	`ASSERT_CLK(a_busy_after_take, in_valid && !in_stall && in_data.request_length != '0 |=> in_stall, "input not stalled during request")

endmodule

bind growing_block_request_splitter gbrs_checker u_checker (.*);
